// File: rtl/core/mexp_pkg.sv
// Shared widths, handshake structs and sequencer states for the modular exponentiation block.
`default_nettype none
package mexp_pkg;

  // Width of every operand, residue and modulus that the datapath works on.
  localparam int WIDTH = 32;
  // Width of the external data fields.
  localparam int FIELD_W = 32;
  // Width of the bit counter of the serial multiplier.
  localparam int CNT_W = $clog2(WIDTH);

  typedef logic [WIDTH-1:0] op_t;

  // Request to the serial modular multiplier: x is the addend and must be
  // below the modulus, y is scanned one bit per cycle from its msb.
  typedef struct packed {
    logic start;
    op_t  x;
    op_t  y;
  } mul_req_t;

  typedef struct packed {
    logic done;
    op_t  product;
  } mul_rsp_t;

  // Finished result from the sequencer to the output register.
  typedef struct packed {
    logic valid;
    op_t  residue;
    logic zero_mod;
  } seq_res_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_REDUCE,
    SEQ_BIT,
    SEQ_MRES,
    SEQ_MSQ,
    SEQ_DONE
  } seq_state_t;

endpackage
`default_nettype wire

// File: rtl/core/mexp_mulmod.sv
// Bit-serial interleaved modular multiplier: one bit of y per cycle.
`default_nettype none
module mexp_mulmod (
  input  wire                  clk,
  input  wire                  rst_n,
  input  mexp_pkg::mul_req_t   req,
  input  mexp_pkg::op_t        modulus,
  output mexp_pkg::mul_rsp_t   rsp
);
  import mexp_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  op_t              acc_r, acc_nxt;
  op_t              x_r, x_nxt;
  op_t              y_r, y_nxt;

  logic [WIDTH+1:0] sum;
  logic [WIDTH+1:0] mod1;
  logic [WIDTH+1:0] mod2;
  logic [WIDTH+1:0] step;

  // One step: acc = (2*acc + bit*x) mod m. The sum stays below 3m, so at
  // most two copies of the modulus come off.
  always_comb begin
    mod1 = {2'b00, modulus};
    mod2 = {1'b0, modulus, 1'b0};
    sum  = {1'b0, acc_r, 1'b0} + (y_r[WIDTH-1] ? {2'b00, x_r} : '0);
    if (sum >= mod2) begin
      step = sum - mod2;
    end else if (sum >= mod1) begin
      step = sum - mod1;
    end else begin
      step = sum;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      x_nxt    = req.x;
      y_nxt    = req.y;
    end else if (busy_r) begin
      acc_nxt = step[WIDTH-1:0];
      y_nxt   = {y_r[WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(WIDTH - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
  end

  assign rsp.done    = done_r;
  assign rsp.product = acc_r;

endmodule
`default_nettype wire

// File: rtl/core/mexp_seq.sv
// Square-and-multiply sequencer: walks the exponent from its lsb and drives the multiplier.
`default_nettype none
module mexp_seq (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  input  mexp_pkg::op_t        base,
  input  mexp_pkg::op_t        exponent,
  input  mexp_pkg::op_t        modulus,
  output logic                 idle,
  output mexp_pkg::seq_res_t   result,
  input  wire                  result_ack,
  output mexp_pkg::mul_req_t   mul_req,
  input  mexp_pkg::mul_rsp_t   mul_rsp
);
  import mexp_pkg::*;

  seq_state_t state_r, state_nxt;
  op_t        expo_r, expo_nxt;
  op_t        res_r, res_nxt;
  op_t        sq_r, sq_nxt;
  logic       err_r, err_nxt;

  logic       mod_zero;
  logic       mod_one;
  logic       expo_last;

  assign mod_zero  = (modulus == '0);
  assign mod_one   = (modulus == op_t'(1));
  // No set bit remains above the current one.
  assign expo_last = (expo_r[WIDTH-1:1] == '0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SEQ_IDLE: begin
        if (start) begin
          if (mod_zero || exponent == '0) begin
            state_nxt = SEQ_DONE;
          end else begin
            state_nxt = SEQ_REDUCE;
          end
        end
      end
      SEQ_REDUCE: begin
        if (mul_rsp.done) begin
          state_nxt = SEQ_BIT;
        end
      end
      SEQ_BIT: begin
        state_nxt = expo_r[0] ? SEQ_MRES : SEQ_MSQ;
      end
      SEQ_MRES: begin
        if (mul_rsp.done) begin
          state_nxt = expo_last ? SEQ_DONE : SEQ_MSQ;
        end
      end
      SEQ_MSQ: begin
        if (mul_rsp.done) begin
          state_nxt = SEQ_BIT;
        end
      end
      SEQ_DONE: begin
        if (result_ack) begin
          state_nxt = SEQ_IDLE;
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  always_comb begin
    expo_nxt      = expo_r;
    res_nxt       = res_r;
    sq_nxt        = sq_r;
    err_nxt       = err_r;
    mul_req.start = 1'b0;
    mul_req.x     = sq_r;
    mul_req.y     = sq_r;
    unique case (state_r)
      SEQ_IDLE: begin
        if (start) begin
          expo_nxt = exponent;
          err_nxt  = mod_zero;
          if (mod_zero) begin
            res_nxt = '0;
          end else if (exponent == '0 || !mod_one) begin
            res_nxt = op_t'(1);
          end else begin
            res_nxt = '0;
          end
          // The base is reduced as (1 mod m) * base; the running result
          // starts at that same 1 mod m.
          mul_req.start = !mod_zero && exponent != '0;
          mul_req.x     = mod_one ? '0 : op_t'(1);
          mul_req.y     = base;
        end
      end
      SEQ_REDUCE: begin
        if (mul_rsp.done) begin
          sq_nxt = mul_rsp.product;
        end
      end
      SEQ_BIT: begin
        mul_req.start = 1'b1;
        mul_req.x     = expo_r[0] ? res_r : sq_r;
        mul_req.y     = sq_r;
      end
      SEQ_MRES: begin
        if (mul_rsp.done) begin
          res_nxt       = mul_rsp.product;
          mul_req.start = !expo_last;
        end
      end
      SEQ_MSQ: begin
        if (mul_rsp.done) begin
          sq_nxt   = mul_rsp.product;
          expo_nxt = {1'b0, expo_r[WIDTH-1:1]};
        end
      end
      SEQ_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    expo_r <= expo_nxt;
    res_r  <= res_nxt;
    sq_r   <= sq_nxt;
    err_r  <= err_nxt;
  end

  assign idle            = (state_r == SEQ_IDLE);
  assign result.valid    = (state_r == SEQ_DONE);
  assign result.residue  = res_r;
  assign result.zero_mod = err_r;

endmodule
`default_nettype wire

// File: rtl/core/modular_exponentiation.sv
// Modular exponentiation top level: modulus register, sequencer, multiplier, output register.
`default_nettype none
// Computes base^exponent mod modulus by right-to-left square-and-multiply on
// one bit-serial modular multiplier. The base is first reduced by one
// multiply; then each scanned exponent bit up to the highest set one takes a
// square, each set bit adds a multiply, and the square after the top bit is
// skipped. A zero exponent or a zero modulus skips the multiplier. One item is
// in flight at a time; the next is taken while the previous result waits in
// the output register. A zero modulus gives residue 0 with the error flag set;
// a zero exponent gives 1. Write the modulus only while idle.
module modular_exponentiation (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire [mexp_pkg::FIELD_W-1:0]   in_base,
  input  wire [mexp_pkg::FIELD_W-1:0]   in_exponent,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [mexp_pkg::FIELD_W-1:0]  out_power_residue,
  output logic                          out_zero_modulus_error,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire [mexp_pkg::FIELD_W-1:0]   cfg_modulus
);
  import mexp_pkg::*;

  logic [FIELD_W-1:0] modulus_r, modulus_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0] out_res_r, out_res_nxt;
  logic               out_err_r, out_err_nxt;

  logic     seq_idle;
  logic     in_xfer;
  logic     slot_free;
  seq_res_t seq_res;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  op_t      mod_op;

  assign mod_op    = op_t'(modulus_r);
  assign in_stall  = !seq_idle;
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = seq_idle;
  // The output register can take a new result when empty or being drained.
  assign slot_free = !out_valid_r || !out_stall;

  mexp_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_xfer),
    .base       (op_t'(in_base)),
    .exponent   (op_t'(in_exponent)),
    .modulus    (mod_op),
    .idle       (seq_idle),
    .result     (seq_res),
    .result_ack (slot_free),
    .mul_req    (mul_req),
    .mul_rsp    (mul_rsp)
  );

  mexp_mulmod u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mul_req),
    .modulus (mod_op),
    .rsp     (mul_rsp)
  );

  always_comb begin
    modulus_nxt   = modulus_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    out_err_nxt   = out_err_r;
    if (cfg_valid && cfg_ready) begin
      modulus_nxt = cfg_modulus;
    end
    if (slot_free) begin
      out_valid_nxt = seq_res.valid;
      if (seq_res.valid) begin
        out_res_nxt = FIELD_W'(seq_res.residue);
        out_err_nxt = seq_res.zero_mod;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r   <= FIELD_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      modulus_r   <= modulus_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    out_err_r <= out_err_nxt;
  end

  assign out_valid              = out_valid_r;
  assign out_power_residue      = out_res_r;
  assign out_zero_modulus_error = out_err_r;

`ifndef SYNTHESIS
  // A flagged result always carries a zero residue.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_modulus_error) |-> (out_power_residue == '0))
    else $error("zero modulus result with nonzero residue");

  // Only one item is in flight: a transfer closes the input at once.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open right after a transfer");

  // The multiplier finishes only while an item is being worked on.
  assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> !seq_idle)
    else $error("multiplier done while sequencer idle");
`endif

endmodule
`default_nettype wire
